// ===== src/sact_pkg.sv =====
package sact_pkg;

    // Fixed field widths
    localparam int ADDR_W     = 32;
    localparam int TAG_W      = 32;
    localparam int STAT_W     = 32;
    localparam int OUT_DATA_W = 104;

    // Register map: index = paddr[3:2]
    localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [1:0] REG_SET_BITS    = 2'd1;
    localparam logic [1:0] REG_WAYS        = 2'd2;
    localparam logic [1:0] REG_MODE        = 2'd3;

    // Register reset values
    localparam logic [3:0] RST_OFFSET_BITS = 4'd4;
    localparam logic [2:0] RST_SET_BITS    = 3'd0;
    localparam logic [3:0] RST_WAYS        = 4'd1;

    // Replacement policy codes
    localparam logic MODE_LRU  = 1'b0;
    localparam logic MODE_FIFO = 1'b1;
    localparam logic RST_MODE  = MODE_LRU;

    // Outcome of one set update
    typedef struct packed {
        logic hit;
        logic evicted;
    } upd_status_t;

endpackage

// ===== src/sact_set_update.sv =====
module sact_set_update #(
    parameter int MAX_WAYS = 8,
    parameter int RANK_W   = 3,
    parameter int CNT_W    = 4
) (
    input  logic [CNT_W-1:0]                         ways_lim,
    input  logic                                     mode,
    input  logic [sact_pkg::TAG_W-1:0]               tag,
    input  logic [MAX_WAYS-1:0]                      row_valid,
    input  logic [MAX_WAYS-1:0][RANK_W-1:0]          row_rank,
    input  logic [MAX_WAYS-1:0][sact_pkg::TAG_W-1:0] row_tag,
    output logic [MAX_WAYS-1:0]                      new_valid,
    output logic [MAX_WAYS-1:0][RANK_W-1:0]          new_rank,
    output logic [MAX_WAYS-1:0][sact_pkg::TAG_W-1:0] new_tag,
    output sact_pkg::upd_status_t                    status
);
    import sact_pkg::*;

    logic [CNT_W-1:0]    count;
    logic                hit;
    logic [RANK_W-1:0]   hit_way;
    logic [RANK_W-1:0]   hit_rank;
    logic                full;
    logic [RANK_W-1:0]   best;
    logic                any;
    logic [RANK_W-1:0]   evict_way;
    logic [RANK_W-1:0]   free_way;
    logic                free_found;
    logic [RANK_W-1:0]   slot;
    logic [MAX_WAYS-1:0] kept;

    // Tag compare across the set, first matching way wins
    always_comb begin
        count   = '0;
        hit     = 1'b0;
        hit_way = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (row_valid[w]) begin
                count = count + CNT_W'(1);
                if (!hit && row_tag[w] == tag) begin
                    hit     = 1'b1;
                    hit_way = RANK_W'(w);
                end
            end
        end
    end

    assign hit_rank = row_rank[hit_way];
    assign full     = (count >= ways_lim);

    // Victim: valid way with the highest rank (first on a tie)
    always_comb begin
        best      = '0;
        any       = 1'b0;
        evict_way = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (row_valid[w] && (!any || row_rank[w] > best)) begin
                best      = row_rank[w];
                evict_way = RANK_W'(w);
                any       = 1'b1;
            end
        end
    end

    // First empty way
    always_comb begin
        free_way   = '0;
        free_found = 1'b0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (!row_valid[w] && !free_found) begin
                free_way   = RANK_W'(w);
                free_found = 1'b1;
            end
        end
    end

    assign slot = full ? evict_way : free_way;

    // New contents of the set
    always_comb begin
        new_valid = row_valid;
        new_rank  = row_rank;
        new_tag   = row_tag;
        kept      = row_valid;
        if (hit) begin
            if (mode == MODE_LRU) begin
                for (int w = 0; w < MAX_WAYS; w++) begin
                    if (row_valid[w] && row_rank[w] < hit_rank) begin
                        new_rank[w] = row_rank[w] + RANK_W'(1);
                    end
                end
                new_rank[hit_way] = '0;
            end
        end else begin
            if (full) begin
                kept[slot] = 1'b0;
            end
            // everything left ages by one, the new line becomes most recent
            for (int w = 0; w < MAX_WAYS; w++) begin
                if (kept[w]) begin
                    new_rank[w] = row_rank[w] + RANK_W'(1);
                end
            end
            new_valid       = kept;
            new_valid[slot] = 1'b1;
            new_tag[slot]   = tag;
            new_rank[slot]  = '0;
        end
    end

    assign status.hit     = hit;
    assign status.evicted = !hit && full;

endmodule

// ===== src/set_associative_cache_tags_core.sv =====
// Set-associative cache tag tracker with LRU or FIFO replacement.
// Input stream (s_axis_*): one word per access, tdata = byte address.
// Output stream (m_axis_*): one word per access with hit/evict flags and
// saturating hit, miss and eviction totals that include this access.
// APB port: offset_bits, set_index_bits, ways_in_use, replace_mode at
// byte addresses 0x0, 0x4, 0x8, 0xC; write only while the block is idle.
// An accepted word is registered at the input stage with its set row read
// from the tag/meta memories, then moves to the output register, where the
// updated row is written back. Throughput: one word per cycle while
// m_axis_tready is high, with a bypass when back-to-back words hit the same set.
// Reset (aresetn low, synchronous) restores register defaults, zeroes the
// totals and starts a clearing pass over the meta memory, one set per
// cycle, over 2^min(7, floor(log2 MAX_SETS)) sets (64 by default), with
// s_axis_tready low. APB writes are taken during the pass.
// When m_axis_tready is low the output register holds its word and one
// more word is held at the input stage; s_axis_tready then drops.
module set_associative_cache_tags_core #(
    parameter int MAX_SETS = 64,
    parameter int MAX_WAYS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [sact_pkg::ADDR_W-1:0]        s_axis_tdata,  // [31:0] address
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] hit, [1] evicted, [33:2] hit_count, [65:34] miss_count,
    // [97:66] eviction_count, [103:98] zero
    output logic [sact_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [3:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import sact_pkg::*;

    // set bits are limited by MAX_SETS and by the 3-bit register
    localparam int IDX_LIM0 = $clog2(MAX_SETS + 1) - 1;
    localparam int IDX_LIM  = (IDX_LIM0 > 7) ? 7 : IDX_LIM0;
    localparam int SETS     = 1 << IDX_LIM;
    localparam int SET_W    = (IDX_LIM > 0) ? IDX_LIM : 1;
    localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CNT_W    = $clog2(MAX_WAYS + 1);
    localparam int META_W   = MAX_WAYS * (1 + RANK_W);
    localparam int TROW_W   = MAX_WAYS * TAG_W;

    // configuration registers
    logic [3:0] offset_bits_reg;
    logic [2:0] set_bits_reg;
    logic [3:0] ways_reg;
    logic       mode_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_bits_reg <= RST_OFFSET_BITS;
            set_bits_reg    <= RST_SET_BITS;
            ways_reg        <= RST_WAYS;
            mode_reg        <= RST_MODE;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_OFFSET_BITS: offset_bits_reg <= pwdata[3:0];
                REG_SET_BITS:    set_bits_reg    <= pwdata[2:0];
                REG_WAYS:        ways_reg        <= pwdata[3:0];
                REG_MODE:        mode_reg        <= pwdata[0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_OFFSET_BITS: prdata = {28'd0, offset_bits_reg};
            REG_SET_BITS:    prdata = {29'd0, set_bits_reg};
            REG_WAYS:        prdata = {28'd0, ways_reg};
            REG_MODE:        prdata = {31'd0, mode_reg};
            default:         prdata = '0;
        endcase
    end

    // effective geometry
    logic [3:0]       eff_set_bits;
    logic [CNT_W-1:0] ways_lim;

    assign eff_set_bits = ({1'b0, set_bits_reg} > 4'(IDX_LIM)) ? 4'(IDX_LIM)
                                                               : {1'b0, set_bits_reg};

    always_comb begin
        if (ways_reg == 4'd0) begin
            ways_lim = CNT_W'(1);
        end else if ({1'b0, ways_reg} > 5'(MAX_WAYS)) begin
            ways_lim = CNT_W'(MAX_WAYS);
        end else begin
            ways_lim = CNT_W'(ways_reg);
        end
    end

    // address split
    logic [ADDR_W-1:0] block;
    logic [ADDR_W-1:0] in_set_raw;
    logic [SET_W-1:0]  in_set;
    logic [TAG_W-1:0]  in_tag;

    assign block      = s_axis_tdata >> offset_bits_reg;
    assign in_set_raw = block & ((ADDR_W'(1) << eff_set_bits) - ADDR_W'(1));
    assign in_set     = in_set_raw[SET_W-1:0];
    assign in_tag     = TAG_W'(block >> eff_set_bits);

    // clearing pass over the meta memory
    logic             clr_busy_reg;
    logic [SET_W-1:0] clr_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_idx_reg <= clr_idx_reg + SET_W'(1);
            if (clr_idx_reg == SET_W'(SETS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // pipeline control
    logic s1_valid_reg;
    logic m_valid_reg;
    logic adv;
    logic accept;

    assign adv           = s1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !clr_busy_reg && (!s1_valid_reg || adv);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // input stage: set/tag and the row read
    logic [SET_W-1:0]  s1_set_reg;
    logic [TAG_W-1:0]  s1_tag_reg;
    logic [META_W-1:0] meta_rd_reg;
    logic [TROW_W-1:0] tag_rd_reg;
    logic              fwd_reg;
    logic [META_W-1:0] fwd_meta_reg;
    logic [TROW_W-1:0] fwd_tag_reg;

    logic [META_W-1:0] meta_mem [SETS];
    logic [TROW_W-1:0] tag_mem  [SETS];

    logic [META_W-1:0] meta_wdata;
    logic [TROW_W-1:0] tag_wdata;
    logic              meta_we;
    logic [SET_W-1:0]  meta_waddr;

    assign meta_we    = clr_busy_reg || adv;
    assign meta_waddr = clr_busy_reg ? clr_idx_reg : s1_set_reg;

    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[meta_waddr] <= clr_busy_reg ? '0 : meta_wdata;
        end
        if (accept) begin
            meta_rd_reg <= meta_mem[in_set];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tag_mem[s1_set_reg] <= tag_wdata;
        end
        if (accept) begin
            tag_rd_reg <= tag_mem[in_set];
        end
    end

    // bypass: word ahead writes the same set at the edge of this read
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_set_reg   <= in_set;
            s1_tag_reg   <= in_tag;
            fwd_reg      <= adv && (s1_set_reg == in_set);
            fwd_meta_reg <= meta_wdata;
            fwd_tag_reg  <= tag_wdata;
        end
    end

    // set update
    logic [META_W-1:0]                 cur_meta;
    logic [TROW_W-1:0]                 cur_tags;
    logic [MAX_WAYS-1:0]               new_valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0]   new_rank;
    logic [MAX_WAYS-1:0][TAG_W-1:0]    new_tag;
    upd_status_t                       upd_st;

    assign cur_meta = fwd_reg ? fwd_meta_reg : meta_rd_reg;
    assign cur_tags = fwd_reg ? fwd_tag_reg : tag_rd_reg;

    sact_set_update #(
        .MAX_WAYS (MAX_WAYS),
        .RANK_W   (RANK_W),
        .CNT_W    (CNT_W)
    ) u_update (
        .ways_lim  (ways_lim),
        .mode      (mode_reg),
        .tag       (s1_tag_reg),
        .row_valid (cur_meta[MAX_WAYS-1:0]),
        .row_rank  (cur_meta[META_W-1:MAX_WAYS]),
        .row_tag   (cur_tags),
        .new_valid (new_valid),
        .new_rank  (new_rank),
        .new_tag   (new_tag),
        .status    (upd_st)
    );

    assign meta_wdata = {new_rank, new_valid};
    assign tag_wdata  = new_tag;

    // saturating totals
    logic [STAT_W-1:0] hit_cnt_reg,   hit_cnt_next;
    logic [STAT_W-1:0] miss_cnt_reg,  miss_cnt_next;
    logic [STAT_W-1:0] evict_cnt_reg, evict_cnt_next;

    assign hit_cnt_next   = (adv && upd_st.hit && hit_cnt_reg != '1)
                          ? hit_cnt_reg + STAT_W'(1) : hit_cnt_reg;
    assign miss_cnt_next  = (adv && !upd_st.hit && miss_cnt_reg != '1)
                          ? miss_cnt_reg + STAT_W'(1) : miss_cnt_reg;
    assign evict_cnt_next = (adv && upd_st.evicted && evict_cnt_reg != '1)
                          ? evict_cnt_reg + STAT_W'(1) : evict_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
        end else begin
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            evict_cnt_reg <= evict_cnt_next;
        end
    end

    // output register
    logic [OUT_DATA_W-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= {6'd0, evict_cnt_next, miss_cnt_next, hit_cnt_next,
                           upd_st.evicted, upd_st.hit};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

`ifndef SYNTH
    // a hit never reports an eviction
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[1])
        else $error("hit word flagged as eviction");

    // a hit bumps the hit total by one unless it is saturated
    assert property (@(posedge aclk) disable iff (!aresetn)
        adv && upd_st.hit |=>
            (hit_cnt_reg == $past(hit_cnt_reg) + STAT_W'(1)) || (hit_cnt_reg == '1))
        else $error("hit total did not advance");

    // every updated set holds at least one line
    assert property (@(posedge aclk) disable iff (!aresetn)
        adv |-> (new_valid != '0))
        else $error("set left empty after update");

    // no word enters while the meta memory is being cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !s1_valid_reg && !accept)
        else $error("word accepted during clearing pass");
`endif

endmodule
